// File: hw/rtl/dpq_pkg.sv
// Package for the double-ended priority queue.
// Holds sizes, command codes and the heap entry type; used by all RTL files but dpq_ram.
package dpq_pkg;

  localparam int CAPACITY = 1024;
  localparam int KEY_BITS = 30;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 30;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT      = 3'd0,
    CMD_EXTRACT_MIN = 3'd1,
    CMD_EXTRACT_MAX = 3'd2,
    CMD_GET_MIN     = 3'd3,
    CMD_GET_MAX     = 3'd4,
    CMD_SIZE        = 3'd5,
    CMD_CLEAR       = 3'd6,
    CMD_UNUSED      = 3'd7
  } cmd_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [IDX_W-1:0]    hnd;
  } entry_t;

endpackage

// File: hw/rtl/double_ended_priority_queue.sv
// Double-ended priority queue top level built from a min-heap and a max-heap.
// Depends on dpq_pkg and dpq_ram.
//
// Usage:
//   Input channel (in_valid/in_ready, in_command, in_key) takes one command;
//   result channel (out_valid/out_ready, out_status, out_value) gives one
//   result per command, in order. in_ready is high only while the sequencer
//   is idle, so one command is in flight at a time.
// Size, clear and error results need no heap access; get_min/get_max read
// one heap root; insert rises in each heap, and extract removes the handle
// from each heap, rising or sinking the moved last entry.
//   The heaps are walked one after the other; each level costs one read of
//   the heap RAM (one read port per heap) plus one compare in the shared
//   comparator, and a sink needs two reads per level for the two children.
// Reset: the queue is empty and every handle is free; no clearing pass.
// A stalled receiver holds the result register; the next command may be
// accepted meanwhile, but its result waits until the register frees up.
module double_ended_priority_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dpq_pkg::CMD_W-1:0]    in_command,
  input  logic [dpq_pkg::KEY_BITS-1:0] in_key,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_status,
  output logic [dpq_pkg::VALUE_W-1:0]  out_value
);
  import dpq_pkg::*;

  typedef enum logic [17:0] {
    S_IDLE     = 18'h00001,
    S_FREE_RD  = 18'h00002,
    S_FREE_Q   = 18'h00004,
    S_ROOT_RD  = 18'h00008,
    S_ROOT_Q   = 18'h00010,
    S_SLOT_RD  = 18'h00020,
    S_SLOT_Q   = 18'h00040,
    S_LAST_RD  = 18'h00080,
    S_LAST_Q   = 18'h00100,
    S_RISE_RD  = 18'h00200,
    S_RISE_Q   = 18'h00400,
    S_PLACE    = 18'h00800,
    S_SINK_L   = 18'h01000,
    S_SINK_LQ  = 18'h02000,
    S_SINK_RQ  = 18'h04000,
    S_SINK_MV  = 18'h08000,
    S_HEAP_END = 18'h10000,
    S_DONE     = 18'h20000
  } state_t;

  localparam int CW = IDX_W + 2;

  state_t               state_r, state_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic                 sel_r, sel_nxt;
  logic [KEY_BITS-1:0]  key_r, key_nxt;
  logic [IDX_W-1:0]     hnd_r, hnd_nxt;
  entry_t               cur_r, cur_nxt;
  entry_t               best_r, best_nxt;
  logic [IDX_W-1:0]     best_idx_r, best_idx_nxt;
  logic                 best_child_r, best_child_nxt;
  logic [IDX_W-1:0]     i_r, i_nxt;
  logic [IDX_W-1:0]     last_r, last_nxt;
  logic                 moved_r, moved_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     hwm_r, hwm_nxt;
  logic                 res_status_r, res_status_nxt;
  logic [VALUE_W-1:0]   res_value_r, res_value_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_status_r, out_status_nxt;
  logic [VALUE_W-1:0]   out_value_r, out_value_nxt;

  // RAM ports
  logic                 h_we;
  logic [IDX_W-1:0]     h_waddr, h_raddr;
  entry_t               h_wdata, h_q0, h_q1, h_q;
  logic                 s_we;
  logic [IDX_W-1:0]     s_waddr, s_wdata, s_raddr, s_q0, s_q1, s_q;
  logic                 f_we;
  logic [IDX_W-1:0]     f_q;

  // shared comparator
  logic [KEY_BITS-1:0]  cmp_a, cmp_b;
  logic                 wins;

  logic                 is_remove;
  logic [IDX_W-1:0]     par_idx;
  logic [CW-1:0]        l_idx, r_idx;
  logic                 l_in, r_in;

  assign is_remove = (cmd_r != CMD_INSERT);
  assign par_idx   = (i_r - IDX_W'(1)) >> 1;
  assign l_idx     = {1'b0, i_r, 1'b1};
  assign r_idx     = l_idx + CW'(1);
  assign l_in      = l_idx < CW'(last_r);
  assign r_in      = r_idx < CW'(last_r);
  assign h_q       = sel_r ? h_q1 : h_q0;
  assign s_q       = sel_r ? s_q1 : s_q0;
  assign wins      = sel_r ? (cmp_a > cmp_b) : (cmp_a < cmp_b);
  assign f_we      = (state_r == S_HEAP_END) && sel_r && is_remove;

  dpq_ram #(.WIDTH($bits(entry_t)), .DEPTH(CAPACITY)) u_min_heap (
    .clk, .we(h_we && !sel_r), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_q0)
  );
  dpq_ram #(.WIDTH($bits(entry_t)), .DEPTH(CAPACITY)) u_max_heap (
    .clk, .we(h_we && sel_r), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_q1)
  );
  dpq_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_min_slot (
    .clk, .we(s_we && !sel_r), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_q0)
  );
  dpq_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_max_slot (
    .clk, .we(s_we && sel_r), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_q1)
  );
  dpq_ram #(.WIDTH(IDX_W), .DEPTH(CAPACITY)) u_free (
    .clk, .we(f_we), .waddr(last_r), .wdata(hnd_r),
    .raddr(count_r[IDX_W-1:0]), .rdata(f_q)
  );

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    sel_nxt        = sel_r;
    key_nxt        = key_r;
    hnd_nxt        = hnd_r;
    cur_nxt        = cur_r;
    best_nxt       = best_r;
    best_idx_nxt   = best_idx_r;
    best_child_nxt = best_child_r;
    i_nxt          = i_r;
    last_nxt       = last_r;
    moved_nxt      = moved_r;
    count_nxt      = count_r;
    hwm_nxt        = hwm_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    h_we    = 1'b0;
    h_waddr = i_r;
    h_wdata = cur_r;
    h_raddr = '0;
    s_we    = 1'b0;
    s_waddr = cur_r.hnd;
    s_wdata = i_r;
    s_raddr = hnd_r;
    cmp_a   = cur_r.key;
    cmp_b   = h_q.key;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt        = cmd_t'(in_command);
          key_nxt        = in_key;
          res_status_nxt = 1'b0;
          res_value_nxt  = '0;
          state_nxt      = S_DONE;
          unique case (cmd_t'(in_command))
            CMD_INSERT: begin
              if (count_r == CNT_W'(CAPACITY)) begin
                res_status_nxt = 1'b1;
              end else begin
                state_nxt = S_FREE_RD;
              end
            end
            CMD_EXTRACT_MIN, CMD_EXTRACT_MAX, CMD_GET_MIN, CMD_GET_MAX: begin
              if (count_r == '0) begin
                res_status_nxt = 1'b1;
              end else begin
                sel_nxt   = (cmd_t'(in_command) == CMD_EXTRACT_MAX) ||
                            (cmd_t'(in_command) == CMD_GET_MAX);
                state_nxt = S_ROOT_RD;
              end
            end
            CMD_SIZE: res_value_nxt = VALUE_W'(count_r);
            CMD_CLEAR: begin
              count_nxt = '0;
              hwm_nxt   = '0;
            end
            default: ;
          endcase
        end
      end
      S_FREE_RD: state_nxt = S_FREE_Q;
      S_FREE_Q: begin
        // slots at or above the high-water mark are taken to hold their own index as handle
        hnd_nxt   = (count_r < hwm_r) ? f_q : count_r[IDX_W-1:0];
        cur_nxt   = '{key: key_r, hnd: hnd_nxt};
        i_nxt     = count_r[IDX_W-1:0];
        sel_nxt   = 1'b0;
        moved_nxt = 1'b0;
        state_nxt = S_RISE_RD;
      end
      S_ROOT_RD: begin
        h_raddr   = '0;
        state_nxt = S_ROOT_Q;
      end
      S_ROOT_Q: begin
        res_value_nxt = VALUE_W'(h_q.key);
        if ((cmd_r == CMD_GET_MIN) || (cmd_r == CMD_GET_MAX)) begin
          state_nxt = S_DONE;
        end else begin
          hnd_nxt   = h_q.hnd;
          last_nxt  = IDX_W'(count_r - CNT_W'(1));
          sel_nxt   = 1'b0;
          state_nxt = S_SLOT_RD;
        end
      end
      S_SLOT_RD: begin
        s_raddr   = hnd_r;
        state_nxt = S_SLOT_Q;
      end
      S_SLOT_Q: begin
        i_nxt     = s_q;
        state_nxt = (s_q == last_r) ? S_HEAP_END : S_LAST_RD;
      end
      S_LAST_RD: begin
        h_raddr   = last_r;
        state_nxt = S_LAST_Q;
      end
      S_LAST_Q: begin
        cur_nxt   = h_q;
        moved_nxt = 1'b0;
        state_nxt = S_RISE_RD;
      end
      S_RISE_RD: begin
        h_raddr = par_idx;
        if (i_r == '0) begin
          state_nxt = (is_remove && !moved_r) ? S_SINK_L : S_PLACE;
        end else begin
          state_nxt = S_RISE_Q;
        end
      end
      S_RISE_Q: begin
        cmp_a = cur_r.key;
        cmp_b = h_q.key;
        if (wins) begin
          // pull the parent down into the hole
          h_we      = 1'b1;
          h_waddr   = i_r;
          h_wdata   = h_q;
          s_we      = 1'b1;
          s_waddr   = h_q.hnd;
          s_wdata   = i_r;
          i_nxt     = par_idx;
          moved_nxt = 1'b1;
          state_nxt = S_RISE_RD;
        end else begin
          state_nxt = (is_remove && !moved_r) ? S_SINK_L : S_PLACE;
        end
      end
      S_PLACE: begin
        h_we      = 1'b1;
        s_we      = 1'b1;
        state_nxt = S_HEAP_END;
      end
      S_SINK_L: begin
        h_raddr        = l_idx[IDX_W-1:0];
        best_nxt       = cur_r;
        best_child_nxt = 1'b0;
        state_nxt      = l_in ? S_SINK_LQ : S_PLACE;
      end
      S_SINK_LQ: begin
        h_raddr = r_idx[IDX_W-1:0];
        cmp_a   = h_q.key;
        cmp_b   = cur_r.key;
        if (wins) begin
          best_nxt       = h_q;
          best_idx_nxt   = l_idx[IDX_W-1:0];
          best_child_nxt = 1'b1;
        end
        state_nxt = r_in ? S_SINK_RQ : S_SINK_MV;
      end
      S_SINK_RQ: begin
        cmp_a = h_q.key;
        cmp_b = best_r.key;
        if (wins) begin
          best_nxt       = h_q;
          best_idx_nxt   = r_idx[IDX_W-1:0];
          best_child_nxt = 1'b1;
        end
        state_nxt = S_SINK_MV;
      end
      S_SINK_MV: begin
        if (best_child_r) begin
          // lift the winning child into the hole
          h_we      = 1'b1;
          h_wdata   = best_r;
          s_we      = 1'b1;
          s_waddr   = best_r.hnd;
          i_nxt     = best_idx_r;
          state_nxt = S_SINK_L;
        end else begin
          state_nxt = S_PLACE;
        end
      end
      S_HEAP_END: begin
        if (!sel_r) begin
          sel_nxt = 1'b1;
          if (is_remove) begin
            state_nxt = S_SLOT_RD;
          end else begin
            cur_nxt   = '{key: key_r, hnd: hnd_r};
            i_nxt     = count_r[IDX_W-1:0];
            moved_nxt = 1'b0;
            state_nxt = S_RISE_RD;
          end
        end else begin
          if (is_remove) begin
            count_nxt = CNT_W'(last_r);
            if (count_r > hwm_r) begin
              hwm_nxt = count_r;
            end
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      hwm_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      hwm_r       <= hwm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    sel_r        <= sel_nxt;
    key_r        <= key_nxt;
    hnd_r        <= hnd_nxt;
    cur_r        <= cur_nxt;
    best_r       <= best_nxt;
    best_idx_r   <= best_idx_nxt;
    best_child_r <= best_child_nxt;
    i_r          <= i_nxt;
    last_r       <= last_nxt;
    moved_r      <= moved_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_value  = out_value_r;

endmodule

// File: hw/rtl/dpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/dpq_checker.sv
// Port-level checker for the double-ended priority queue, with its bind.
// Depends on dpq_pkg; attaches to double_ended_priority_queue.
module dpq_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         out_status,
  input logic [dpq_pkg::VALUE_W-1:0]  out_value
);
  import dpq_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_status))
    else $error("stalled result changed");

  // sequencer is busy right after a transfer in
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // errors carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_value == '0)
    else $error("error result with nonzero value");

  // no result straight out of reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind double_ended_priority_queue dpq_checker u_dpq_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_status, .out_value
);

// File: test/tb_top.sv
// Testbench for the double-ended priority queue.
// Drives random command streams, predicts each result with a twin-heap model.
// Depends on dpq_pkg and the double_ended_priority_queue RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dpq_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 300;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [KEY_BITS-1:0] key;
  } cmd_item_t;

  typedef struct packed {
    logic               status;
    logic [VALUE_W-1:0] value;
  } result_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, out_status;
  logic [CMD_W-1:0]    in_command;
  logic [KEY_BITS-1:0] in_key;
  logic [VALUE_W-1:0]  out_value;

  double_ended_priority_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_key(in_key),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_status(out_status), .out_value(out_value)
  );

  // Model state
  logic [KEY_BITS-1:0] lo_key [CAPACITY];
  logic [IDX_W-1:0]    lo_hnd [CAPACITY];
  logic [KEY_BITS-1:0] hi_key [CAPACITY];
  logic [IDX_W-1:0]    hi_hnd [CAPACITY];
  int                  lo_slot [CAPACITY];
  int                  hi_slot [CAPACITY];
  logic [IDX_W-1:0]    free_hnd [CAPACITY];
  int                  fill;

  cmd_item_t pending_cmds[$];
  result_t   expected_results[$];
  int        error_count;
  int        send_idle_pct, recv_idle_pct;
  logic      hold_active;
  event      hold_go;

  function automatic bit beats(bit is_hi, logic [KEY_BITS-1:0] a, logic [KEY_BITS-1:0] b);
    return is_hi ? (a > b) : (a < b);
  endfunction

  function automatic logic [KEY_BITS-1:0] key_at(bit is_hi, int i);
    return is_hi ? hi_key[i] : lo_key[i];
  endfunction

  function automatic void swap_slots(bit is_hi, int a, int b);
    logic [KEY_BITS-1:0] tk;
    logic [IDX_W-1:0] th;
    if (is_hi) begin
      tk = hi_key[a]; th = hi_hnd[a];
      hi_key[a] = hi_key[b]; hi_hnd[a] = hi_hnd[b];
      hi_key[b] = tk; hi_hnd[b] = th;
      hi_slot[hi_hnd[a]] = a; hi_slot[hi_hnd[b]] = b;
    end else begin
      tk = lo_key[a]; th = lo_hnd[a];
      lo_key[a] = lo_key[b]; lo_hnd[a] = lo_hnd[b];
      lo_key[b] = tk; lo_hnd[b] = th;
      lo_slot[lo_hnd[a]] = a; lo_slot[lo_hnd[b]] = b;
    end
  endfunction

  function automatic void sift_up(bit is_hi, int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!beats(is_hi, key_at(is_hi, i), key_at(is_hi, p))) break;
      swap_slots(is_hi, i, p);
      i = p;
    end
  endfunction

  function automatic void sift_down(bit is_hi, int i, int n);
    int l, r, best;
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      best = i;
      if (l < n && beats(is_hi, key_at(is_hi, l), key_at(is_hi, best))) best = l;
      if (r < n && beats(is_hi, key_at(is_hi, r), key_at(is_hi, best))) best = r;
      if (best == i) break;
      swap_slots(is_hi, i, best);
      i = best;
    end
  endfunction

  function automatic void drop_handle(bit is_hi, logic [IDX_W-1:0] h, int n);
    int i;
    i = is_hi ? hi_slot[h] : lo_slot[h];
    if (i != n - 1) begin
      swap_slots(is_hi, i, n - 1);
      sift_up(is_hi, i);
      sift_down(is_hi, i, n - 1);
    end
  endfunction

  function automatic void reset_free_store();
    for (int i = 0; i < CAPACITY; i++) free_hnd[i] = IDX_W'(i);
    fill = 0;
  endfunction

  function automatic result_t queue_step(cmd_item_t c);
    result_t r;
    logic [IDX_W-1:0] h;
    bit from_hi;
    r = '0;
    case (cmd_t'(c.command))
      CMD_INSERT: begin
        if (fill >= CAPACITY) r.status = 1'b1;
        else begin
          h = free_hnd[fill];
          lo_key[fill] = c.key; lo_hnd[fill] = h; lo_slot[h] = fill;
          hi_key[fill] = c.key; hi_hnd[fill] = h; hi_slot[h] = fill;
          sift_up(1'b0, fill);
          sift_up(1'b1, fill);
          fill++;
        end
      end
      CMD_EXTRACT_MIN, CMD_EXTRACT_MAX, CMD_GET_MIN, CMD_GET_MAX: begin
        if (fill == 0) r.status = 1'b1;
        else begin
          from_hi = (c.command == CMD_EXTRACT_MAX || c.command == CMD_GET_MAX);
          r.value = from_hi ? hi_key[0] : lo_key[0];
          if (c.command == CMD_EXTRACT_MIN || c.command == CMD_EXTRACT_MAX) begin
            h = from_hi ? hi_hnd[0] : lo_hnd[0];
            drop_handle(1'b0, h, fill);
            drop_handle(1'b1, h, fill);
            fill--;
            free_hnd[fill] = h;
          end
        end
      end
      CMD_SIZE: r.value = VALUE_W'(fill);
      CMD_CLEAR: reset_free_store();
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("tb_top: mismatch %s got %0h want %0h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  function automatic void push(cmd_t c, logic [KEY_BITS-1:0] k);
    cmd_item_t it;
    it.command = c;
    it.key = k;
    pending_cmds.push_back(it);
  endfunction

  function automatic logic [KEY_BITS-1:0] rand_key();
    case ($urandom_range(0, 3))
      0: return KEY_BITS'($urandom_range(0, 15));
      1: return {KEY_BITS{1'b1}} - KEY_BITS'($urandom_range(0, 3));
      default: return KEY_BITS'($urandom);
    endcase
  endfunction

  // Random phase: bias toward insert/extract mixes.
  function automatic void add_random(int count);
    int sel;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) push(CMD_INSERT, rand_key());
      else if (sel < 55) push(CMD_EXTRACT_MIN, KEY_BITS'($urandom));
      else if (sel < 70) push(CMD_EXTRACT_MAX, KEY_BITS'($urandom));
      else if (sel < 78) push(CMD_GET_MIN, KEY_BITS'($urandom));
      else if (sel < 86) push(CMD_GET_MAX, KEY_BITS'($urandom));
      else if (sel < 93) push(CMD_SIZE, KEY_BITS'($urandom));
      else if (sel < 96) push(CMD_UNUSED, KEY_BITS'($urandom));
      else push(CMD_CLEAR, KEY_BITS'($urandom));
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver hold-off, counted here so the monitor only reads it
  initial begin
    hold_active = 1'b0;
    forever begin
      @(hold_go);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  // Driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_command <= '0;
      in_key <= '0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(queue_step(pending_cmds.pop_front()));
      end
      if ((!in_valid || in_ready) && pending_cmds.size() > 0 &&
          !(in_valid && in_ready && pending_cmds.size() == 1) &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        // offer the head; after a transfer the queue already popped it
        in_valid <= 1'b1;
        in_command <= (in_valid && in_ready) ? pending_cmds[0].command : pending_cmds[0].command;
        in_key <= pending_cmds[0].key;
      end else if (in_valid && in_ready) begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 32'(out_value), '0);
        end else begin
          want = expected_results.pop_front();
          if (out_status !== want.status)
            report_mismatch("status", 32'(out_status), 32'(want.status));
          if (out_value !== want.value)
            report_mismatch("value", 32'(out_value), 32'(want.value));
        end
      end
      if (hold_active) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog
  int stall_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    error_count = 0;
    send_idle_pct = 24;
    recv_idle_pct = 61;
    reset_free_store();
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty errors, extremes, ties, every command.
    push(CMD_EXTRACT_MIN, '0);
    push(CMD_EXTRACT_MAX, '0);
    push(CMD_GET_MIN, '0);
    push(CMD_GET_MAX, '0);
    push(CMD_SIZE, '0);
    push(CMD_INSERT, {KEY_BITS{1'b1}});
    push(CMD_INSERT, '0);
    push(CMD_INSERT, 30'h155_5555);
    push(CMD_INSERT, 30'h155_5555);
    push(CMD_INSERT, 30'h2AAA_AAAA);
    push(CMD_GET_MIN, '0);
    push(CMD_GET_MAX, '0);
    push(CMD_SIZE, '0);
    push(CMD_UNUSED, {KEY_BITS{1'b1}});
    push(CMD_EXTRACT_MAX, '0);
    push(CMD_EXTRACT_MIN, '0);
    push(CMD_EXTRACT_MIN, '0);
    push(CMD_EXTRACT_MAX, '0);
    push(CMD_EXTRACT_MIN, '0);
    push(CMD_SIZE, '0);
    push(CMD_INSERT, 30'd7);
    push(CMD_CLEAR, '0);
    push(CMD_SIZE, '0);
    push(CMD_GET_MIN, '0);
    add_random(220);
    wait (pending_cmds.size() == 0);

    send_idle_pct = 61;
    recv_idle_pct = 24;
    add_random(220);
    wait (pending_cmds.size() == 0);

    // Long receiver hold-off while the sender keeps offering, then drain.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    push(CMD_CLEAR, '0);
    for (int i = 0; i < 60; i++) push(CMD_INSERT, rand_key());
    push(CMD_SIZE, '0);
    -> hold_go;
    for (int i = 0; i < 40; i++) push(cmd_t'($urandom_range(1, 2)), '0);
    push(CMD_CLEAR, '0);
    add_random(130);
    wait (pending_cmds.size() == 0);

    wait (expected_results.size() == 0);
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end
endmodule

// File: filelist.f
hw/rtl/dpq_pkg.sv
hw/rtl/dpq_ram.sv
hw/rtl/double_ended_priority_queue.sv
hw/rtl/dpq_checker.sv
test/tb_top.sv
